>>> rtl/rta_pkg.sv
// ============================================================================
// Runtime accounting package
// Widths, codes, state encoding and the divider response bundle shared by
// the runtime accounting modules.
// ============================================================================
package rta_pkg;

  localparam int unsigned MS_W      = 48;  // millisecond timestamps
  localparam int unsigned SEC_W     = 39;  // second numbers (ms / 1000)
  localparam int unsigned SCORE_W   = 16;  // activity score
  localparam int unsigned IDX_W     = 8;   // read index
  localparam int unsigned TOT_W     = 64;  // running totals
  localparam int unsigned BKT_W     = 16;  // bucket contents
  localparam int unsigned REM_W     = 10;  // divider remainder and divisor
  localparam int unsigned PROD_W    = MS_W + SCORE_W;

  // The divider retires this many quotient bits per cycle.
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_STEPS = MS_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [REM_W-1:0] MS_PER_SEC = REM_W'(1000);
  localparam logic [BKT_W-1:0] BUCKET_MAX = {BKT_W{1'b1}};

  // Command codes.
  localparam logic CMD_ACCOUNT = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_SEC,
    ST_DIV_SLOT,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_DIV_RIDX,
    ST_READ_RD,
    ST_READ_CAP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              done;
    logic [MS_W-1:0]   quot_a;
    logic [MS_W-1:0]   quot_b;
    logic [REM_W-1:0]  rem_a;
    logic [REM_W-1:0]  rem_b;
  } div_rsp_t;

endpackage

>>> rtl/per_second_runtime_accounting.sv
// ============================================================================
// Per-second runtime accounting
// Splits run intervals over wall-clock seconds into a ring of buckets and
// keeps raw and score-weighted runtime totals; read words return a bucket.
// ============================================================================
// An account word divides both interval ends by 1000, the first walked second
// by RING_DEPTH for its slot, then reads and writes one bucket per second
// walked (1 to RING_DEPTH); a reversed interval ends after the first divide,
// and a read word divides its index, then reads and captures a bucket. Busy
// drops in the cycle after the result; one divider serves every divide. Reset
// clears the totals and marks every bucket empty; the receiver cannot stall.
module per_second_runtime_accounting #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           cmd_i,
  input  logic [rta_pkg::MS_W-1:0]       run_start_ms_i,
  input  logic [rta_pkg::MS_W-1:0]       now_ms_i,
  input  logic [rta_pkg::SCORE_W-1:0]    activity_score_i,
  input  logic [rta_pkg::IDX_W-1:0]      read_index_i,
  output logic                           result_valid_o,
  output logic [rta_pkg::TOT_W-1:0]      period_runtime_ms_o,
  output logic [rta_pkg::TOT_W-1:0]      weighted_runtime_o,
  output logic [rta_pkg::SEC_W-1:0]      bucket_second_o,
  output logic [rta_pkg::BKT_W-1:0]      bucket_ms_o,
  output logic                           reversed_o
);

  localparam int unsigned SLOT_W = $clog2(RING_DEPTH);
  localparam int unsigned SEC_W  = rta_pkg::SEC_W;
  localparam int unsigned REM_W  = rta_pkg::REM_W;
  localparam int unsigned MS_W   = rta_pkg::MS_W;
  localparam logic [REM_W-1:0]  DEPTH_DIV  = REM_W'(RING_DEPTH);
  localparam logic [SEC_W-1:0]  DEPTH_SEC  = SEC_W'(RING_DEPTH);
  localparam logic [SEC_W-1:0]  DEPTH_M1   = SEC_W'(RING_DEPTH - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(RING_DEPTH - 1);

  rta_pkg::state_e state_q, state_d;

  // Sequencer-driven controls.
  logic                    div_start;
  logic [REM_W-1:0]        div_divisor;
  logic [MS_W-1:0]         div_dividend_a, div_dividend_b;
  rta_pkg::div_rsp_t       div_rsp;
  logic                    ring_rd_en, ring_wr_en;

  // Captured item and working registers.
  logic                         cmd_q;
  logic                         rev_q;
  logic [MS_W-1:0]              len_q;
  logic [rta_pkg::SCORE_W-1:0]  mult_q;
  logic [rta_pkg::PROD_W-1:0]   prod_q;
  logic [SEC_W-1:0]             s0_q, s1_q, sec_q;
  logic [REM_W-1:0]             r0_q, r1_q;
  logic [SLOT_W-1:0]            slot_q;
  logic [rta_pkg::TOT_W-1:0]    raw_q, wt_q;
  logic [SEC_W-1:0]             sec_out_q;
  logic [rta_pkg::BKT_W-1:0]    ms_out_q;

  // Ring read data and the bucket update.
  logic [SEC_W-1:0]             rd_tag;
  logic [rta_pkg::BKT_W-1:0]    rd_rt;
  logic [SEC_W-1:0]             s0_w, s1_w, span_w, first_w;
  logic [REM_W-1:0]             share_hi, share_lo, share;
  logic [rta_pkg::BKT_W-1:0]    base_rt, new_rt;
  logic [rta_pkg::BKT_W:0]      sum_rt;
  logic                         last_sec;

  rta_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (div_start),
    .divisor_i    (div_divisor),
    .dividend_a_i (div_dividend_a),
    .dividend_b_i (div_dividend_b),
    .rsp_o        (div_rsp)
  );

  rta_ring #(
    .DEPTH  (RING_DEPTH),
    .SLOT_W (SLOT_W)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (ring_rd_en),
    .rd_addr_i (slot_q),
    .wr_en_i   (ring_wr_en),
    .wr_addr_i (slot_q),
    .wr_tag_i  (sec_q),
    .wr_rt_i   (new_rt),
    .rd_tag_o  (rd_tag),
    .rd_rt_o   (rd_rt)
  );

  // Seconds of the interval ends straight from the divider. Only the last
  // RING_DEPTH seconds are walked; older ones would be overwritten anyway.
  assign s0_w    = div_rsp.quot_a[SEC_W-1:0];
  assign s1_w    = div_rsp.quot_b[SEC_W-1:0];
  assign span_w  = s1_w - s0_w;
  assign first_w = (span_w >= DEPTH_SEC) ? (s1_w - DEPTH_M1) : s0_w;

  // A second's share: it runs from its start (or the interval start in the
  // first second) to its end (or the interval end in the last second). A
  // second in front of the walk that was skipped never counts as the start.
  assign last_sec = (sec_q == s1_q);
  assign share_hi = last_sec ? r1_q : rta_pkg::MS_PER_SEC;
  assign share_lo = (sec_q == s0_q) ? r0_q : '0;
  assign share    = share_hi - share_lo;

  // A bucket tagged with another second starts over from zero.
  assign base_rt = (rd_tag == sec_q) ? rd_rt : '0;
  assign sum_rt  = {1'b0, base_rt} + (rta_pkg::BKT_W + 1)'(share);
  assign new_rt  = sum_rt[rta_pkg::BKT_W] ? rta_pkg::BUCKET_MAX : sum_rt[rta_pkg::BKT_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rta_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = (cmd_i == rta_pkg::CMD_READ) ? rta_pkg::ST_DIV_RIDX : rta_pkg::ST_DIV_SEC;
        end
      end
      rta_pkg::ST_DIV_SEC: begin
        if (div_rsp.done) begin
          state_d = rev_q ? rta_pkg::ST_DONE : rta_pkg::ST_DIV_SLOT;
        end
      end
      rta_pkg::ST_DIV_SLOT: begin
        if (div_rsp.done) begin
          state_d = rta_pkg::ST_WALK_RD;
        end
      end
      rta_pkg::ST_WALK_RD: begin
        state_d = rta_pkg::ST_WALK_WR;
      end
      rta_pkg::ST_WALK_WR: begin
        state_d = last_sec ? rta_pkg::ST_DONE : rta_pkg::ST_WALK_RD;
      end
      rta_pkg::ST_DIV_RIDX: begin
        if (div_rsp.done) begin
          state_d = rta_pkg::ST_READ_RD;
        end
      end
      rta_pkg::ST_READ_RD: begin
        state_d = rta_pkg::ST_READ_CAP;
      end
      rta_pkg::ST_READ_CAP: begin
        state_d = rta_pkg::ST_DONE;
      end
      rta_pkg::ST_DONE: begin
        state_d = rta_pkg::ST_IDLE;
      end
      default: begin
        state_d = rta_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    div_start      = 1'b0;
    div_divisor    = DEPTH_DIV;
    div_dividend_a = MS_W'(first_w);
    div_dividend_b = MS_W'(first_w);
    ring_rd_en     = 1'b0;
    ring_wr_en     = 1'b0;
    unique case (state_q)
      rta_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          div_start = 1'b1;
          if (cmd_i == rta_pkg::CMD_READ) begin
            div_dividend_a = MS_W'(read_index_i);
            div_dividend_b = MS_W'(read_index_i);
          end else begin
            div_divisor    = rta_pkg::MS_PER_SEC;
            div_dividend_a = run_start_ms_i;
            div_dividend_b = now_ms_i;
          end
        end
      end
      rta_pkg::ST_DIV_SEC: begin
        div_start = div_rsp.done && !rev_q;
      end
      rta_pkg::ST_WALK_RD,
      rta_pkg::ST_READ_RD: begin
        ring_rd_en = 1'b1;
      end
      rta_pkg::ST_WALK_WR: begin
        ring_wr_en = 1'b1;
      end
      rta_pkg::ST_DONE: begin
        result_valid_o = 1'b1;
      end
      rta_pkg::ST_DIV_SLOT,
      rta_pkg::ST_DIV_RIDX,
      rta_pkg::ST_READ_CAP: begin
        busy_o = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  // Control state and the running totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rta_pkg::ST_IDLE;
      raw_q   <= '0;
      wt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == rta_pkg::ST_WALK_WR && last_sec) begin
        raw_q <= raw_q + rta_pkg::TOT_W'(len_q);
        wt_q  <= wt_q + rta_pkg::TOT_W'(prod_q);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rta_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_q  <= cmd_i;
          rev_q  <= (cmd_i == rta_pkg::CMD_ACCOUNT) && (now_ms_i < run_start_ms_i);
          len_q  <= now_ms_i - run_start_ms_i;
          mult_q <= (activity_score_i == '0) ? rta_pkg::SCORE_W'(1) : activity_score_i;
        end
      end
      rta_pkg::ST_DIV_SEC: begin
        prod_q <= len_q * mult_q;
        if (div_rsp.done) begin
          s0_q  <= s0_w;
          s1_q  <= s1_w;
          r0_q  <= div_rsp.rem_a;
          r1_q  <= div_rsp.rem_b;
          sec_q <= first_w;
          if (rev_q) begin
            sec_out_q <= s1_w;
            ms_out_q  <= '0;
          end
        end
      end
      rta_pkg::ST_DIV_SLOT,
      rta_pkg::ST_DIV_RIDX: begin
        if (div_rsp.done) begin
          slot_q <= div_rsp.rem_a[SLOT_W-1:0];
        end
      end
      rta_pkg::ST_WALK_WR: begin
        if (last_sec) begin
          sec_out_q <= sec_q;
          ms_out_q  <= new_rt;
        end else begin
          sec_q  <= sec_q + 1'b1;
          slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
        end
      end
      rta_pkg::ST_READ_CAP: begin
        sec_out_q <= rd_tag;
        ms_out_q  <= rd_rt;
      end
      rta_pkg::ST_WALK_RD,
      rta_pkg::ST_READ_RD,
      rta_pkg::ST_DONE: begin
        slot_q <= slot_q;
      end
      default: begin
        slot_q <= slot_q;
      end
    endcase
  end

  assign period_runtime_ms_o = raw_q;
  assign weighted_runtime_o  = wt_q;
  assign bucket_second_o     = sec_out_q;
  assign bucket_ms_o         = ms_out_q;
  assign reversed_o          = rev_q;

  // A result word always ends the item and frees the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy_o && !result_valid_o)
    else $error("result not followed by idle");

  // A reversed interval never reports bucket time and never comes from a read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && reversed_o) |-> (bucket_ms_o == '0) && (cmd_q == rta_pkg::CMD_ACCOUNT))
    else $error("reversed result carries bucket time");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == rta_pkg::ST_DIV_SEC) || (state_q == rta_pkg::ST_DIV_SLOT) ||
                     (state_q == rta_pkg::ST_DIV_RIDX))
    else $error("divider result outside a divide phase");

  // Totals only move on account words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q == rta_pkg::CMD_READ && busy_o) |=> $stable(raw_q) && $stable(wt_q))
    else $error("totals changed during a read");

endmodule

>>> rtl/rta_div.sv
// ============================================================================
// Two-lane radix-16 divider
// Restoring division of two 48-bit dividends by one small divisor, four
// quotient bits per cycle, done pulse registered along with the last step.
// ============================================================================
module rta_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rta_pkg::REM_W-1:0]   divisor_i,
  input  logic [rta_pkg::MS_W-1:0]    dividend_a_i,
  input  logic [rta_pkg::MS_W-1:0]    dividend_b_i,
  output rta_pkg::div_rsp_t           rsp_o
);

  localparam int unsigned RW = rta_pkg::REM_W;
  localparam int unsigned DB = rta_pkg::DIV_BITS;
  localparam int unsigned MW = rta_pkg::MS_W;

  logic                              busy_q, done_q;
  logic [rta_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [RW-1:0]                     divisor_q;
  logic [MW-1:0]                     work_a_q, work_b_q;
  logic [RW-1:0]                     rem_a_q, rem_b_q;
  logic [RW+DB-1:0]                  step_a, step_b;

  // Four restoring steps on a remainder that always stays below the divisor.
  function automatic logic [RW+DB-1:0] step4(input logic [RW-1:0] rem,
                                             input logic [DB-1:0] bits,
                                             input logic [RW-1:0] dv);
    logic [RW:0]   t;
    logic [RW-1:0] r;
    logic [DB-1:0] q;
    r = rem;
    q = '0;
    for (int i = DB - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, dv}) begin
        t    = t - {1'b0, dv};
        q[i] = 1'b1;
      end
      r = t[RW-1:0];
    end
    return {r, q};
  endfunction

  assign step_a = step4(rem_a_q, work_a_q[MW-1 -: DB], divisor_q);
  assign step_b = step4(rem_b_q, work_b_q[MW-1 -: DB], divisor_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == rta_pkg::DIV_CNT_W'(rta_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      divisor_q <= divisor_i;
      work_a_q  <= dividend_a_i;
      work_b_q  <= dividend_b_i;
      rem_a_q   <= '0;
      rem_b_q   <= '0;
    end else if (busy_q) begin
      work_a_q <= {work_a_q[MW-DB-1:0], step_a[DB-1:0]};
      work_b_q <= {work_b_q[MW-DB-1:0], step_b[DB-1:0]};
      rem_a_q  <= step_a[RW+DB-1:DB];
      rem_b_q  <= step_b[RW+DB-1:DB];
    end
  end

  always_comb begin
    rsp_o.done   = done_q;
    rsp_o.quot_a = work_a_q;
    rsp_o.quot_b = work_b_q;
    rsp_o.rem_a  = rem_a_q;
    rsp_o.rem_b  = rem_b_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> busy_q && !done_q)
    else $error("divider did not start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done longer than one cycle");

endmodule

>>> rtl/rta_ring.sv
// ============================================================================
// Bucket ring memory
// Second tag and millisecond count per bucket, one read and one write port,
// registered read data, valid bits so unwritten buckets read as zero.
// ============================================================================
module rta_ring #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned SLOT_W = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [SLOT_W-1:0]           rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [SLOT_W-1:0]           wr_addr_i,
  input  logic [rta_pkg::SEC_W-1:0]   wr_tag_i,
  input  logic [rta_pkg::BKT_W-1:0]   wr_rt_i,
  output logic [rta_pkg::SEC_W-1:0]   rd_tag_o,
  output logic [rta_pkg::BKT_W-1:0]   rd_rt_o
);

  logic [rta_pkg::SEC_W-1:0] tag_mem [DEPTH];
  logic [rta_pkg::BKT_W-1:0] rt_mem  [DEPTH];
  logic [DEPTH-1:0]          valid_q;
  logic                      rd_vld_q;
  logic [rta_pkg::SEC_W-1:0] rd_tag_q;
  logic [rta_pkg::BKT_W-1:0] rd_rt_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_mem[wr_addr_i] <= wr_tag_i;
      rt_mem[wr_addr_i]  <= wr_rt_i;
    end
    if (rd_en_i) begin
      rd_tag_q <= tag_mem[rd_addr_i];
      rd_rt_q  <= rt_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  // A bucket that was never written reads as tag zero and no run time.
  assign rd_tag_o = rd_vld_q ? rd_tag_q : '0;
  assign rd_rt_o  = rd_vld_q ? rd_rt_q  : '0;

endmodule
